// ----- rtl/mcl_pkg.sv -----
package mcl_pkg;

  localparam int DEF_DIM_BITS   = 16;
  localparam int DEF_MAX_LEVELS = 17;
  localparam int DEF_MAX_LAYERS = 256;

  // layer count field holds up to 4095
  localparam int LAYER_W      = 12;
  localparam int LEVEL_W      = 5;
  localparam int ALIGN_DEF_LG = 2;   // alignment 0 means 4 bytes
  localparam int BYTE_SHIFT   = 3;   // bits to bytes
  localparam int IN_DATA_W    = 176;
  localparam int OUT_DATA_W   = 256;

  typedef struct packed {
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        d;
    logic [7:0]         bits;
    logic [4:0]         bw;
    logic [4:0]         bh;
    logic [9:0]         step;
    logic [31:0]        pmin;
    logic [31:0]        smin;
    logic [4:0]         align_lg;
    logic [LAYER_W-1:0] layers;
    logic [LEVEL_W-1:0] limit;
  } mcl_desc_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_index;
    logic [15:0]        lvl_width;
    logic [15:0]        lvl_height;
    logic [15:0]        lvl_depth;
    logic [9:0]         step_out;
    logic [31:0]        row_pitch;
    logic [31:0]        slice_bytes;
    logic [31:0]        plane_bytes;
    logic [44:0]        first_offset;
    logic [44:0]        total_bytes;
    logic               last_level;
    logic               error_flag;
  } mcl_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASIZE,
    ST_PITCH,
    ST_SLICE,
    ST_PLANE,
    ST_ADD,
    ST_EMIT
  } mcl_state_e;

endpackage

// ----- rtl/mcl_queue.sv -----
module mcl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mcl_pkg::mcl_desc_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output mcl_pkg::mcl_desc_t data_o,
  output logic               empty_o
);
  import mcl_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  mcl_desc_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/mcl_front.sv -----
module mcl_front #(
  parameter int DIM_BITS   = mcl_pkg::DEF_DIM_BITS,
  parameter int MAX_LEVELS = mcl_pkg::DEF_MAX_LEVELS,
  parameter int MAX_LAYERS = mcl_pkg::DEF_MAX_LAYERS
) (
  input  logic [15:0]        base_width_i,
  input  logic [15:0]        base_height_i,
  input  logic [15:0]        base_depth_i,
  input  logic [7:0]         bits_per_block_i,
  input  logic [4:0]         block_width_i,
  input  logic [4:0]         block_height_i,
  input  logic [9:0]         step_bits_i,
  input  logic [31:0]        pitch_min_i,
  input  logic [31:0]        slice_min_i,
  input  logic [16:0]        align_request_i,
  input  logic [8:0]         layer_count_i,
  input  logic [4:0]         level_limit_i,
  output mcl_pkg::mcl_desc_t desc_o
);
  import mcl_pkg::*;

  localparam logic [15:0] DimMask = 16'((32'd1 << DIM_BITS) - 1);

  // log2 of the smallest power of two not below a, or ALIGN_DEF_LG when a is zero
  function automatic logic [4:0] align_log2(logic [16:0] a);
    logic [4:0] lg;
    lg = 5'd17;
    for (int k = 16; k >= 0; k--) begin
      if ((18'd1 << k) >= {1'b0, a}) lg = 5'(k);
    end
    if (a == '0) lg = 5'(ALIGN_DEF_LG);
    return lg;
  endfunction

  function automatic logic [15:0] dim_in(logic [15:0] v);
    logic [15:0] m;
    m = v & DimMask;
    return (m == '0) ? 16'd1 : m;
  endfunction

  logic [LAYER_W-1:0] layers;

  always_comb begin
    layers = (layer_count_i == '0) ? LAYER_W'(1) : LAYER_W'(layer_count_i);
    if (layers > LAYER_W'(MAX_LAYERS)) layers = LAYER_W'(MAX_LAYERS);

    desc_o.w        = dim_in(base_width_i);
    desc_o.h        = dim_in(base_height_i);
    desc_o.d        = dim_in(base_depth_i);
    desc_o.bits     = bits_per_block_i;
    desc_o.bw       = block_width_i;
    desc_o.bh       = block_height_i;
    desc_o.step     = (step_bits_i < 10'(bits_per_block_i)) ? 10'(bits_per_block_i)
                                                            : step_bits_i;
    desc_o.pmin     = pitch_min_i;
    desc_o.smin     = slice_min_i;
    desc_o.align_lg = align_log2(align_request_i);
    desc_o.layers   = layers;
    desc_o.limit    = (level_limit_i == '0 || level_limit_i > LEVEL_W'(MAX_LEVELS))
                      ? LEVEL_W'(MAX_LEVELS) : level_limit_i;
  end

endmodule

// ----- rtl/mcl_back.sv -----
module mcl_back #(
  parameter int MAX_LEVELS = mcl_pkg::DEF_MAX_LEVELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  mcl_pkg::mcl_desc_t   desc_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output mcl_pkg::mcl_result_t res_o
);
  import mcl_pkg::*;

  function automatic logic [16:0] round_blk(logic [15:0] v, logic [4:0] b);
    logic [16:0] m;
    m = 17'(b) - 17'd1;
    return (17'(v) + m) & ~m;
  endfunction

  mcl_state_e          state_q, state_d;
  mcl_desc_t           desc_q;
  logic [15:0]         w_q, h_q, d_q;
  logic [31:0]         pmin_q, smin_q;
  logic [LEVEL_W-1:0]  lvl_q;
  logic [16:0]         ah_q;
  logic [26:0]         prod_q;
  logic [24:0]         chk_q;
  logic [31:0]         pitch_q, slice_q, plane_q;
  logic [43:0]         add_q;
  logic [44:0]         offset_q;
  logic                out_valid_q;
  mcl_result_t         out_q;

  logic [16:0]         aw;
  logic [31:0]         amask, pitch_raw, pitch_max, slice_max;
  logic [48:0]         slice_prod;
  logic [47:0]         plane_prod;
  logic [43:0]         add_prod;
  logic [44:0]         total;
  logic                bad, last_lvl, emit_last, out_load;
  mcl_result_t         err_word;

  always_comb begin
    aw         = round_blk(w_q, desc_q.bw);
    amask      = 32'((33'd1 << desc_q.align_lg) - 33'd1);
    pitch_raw  = {8'd0, prod_q[26:BYTE_SHIFT]};
    pitch_max  = (pitch_raw < pmin_q) ? pmin_q : pitch_raw;
    slice_prod = pitch_q * ah_q;
    slice_max  = (slice_q < smin_q) ? smin_q : slice_q;
    plane_prod = slice_max * d_q;
    add_prod   = plane_q * desc_q.layers;
    total      = offset_q + {1'b0, add_q};
    bad        = (lvl_q == '0) &&
                 ((desc_q.bits == '0) || (pitch_q < {10'd0, chk_q[24:BYTE_SHIFT]}) ||
                  ((slice_q & amask) != '0));
    last_lvl   = ({1'b0, lvl_q} + 6'd1 >= {1'b0, desc_q.limit}) ||
                 (w_q == 16'd1 && h_q == 16'd1 && d_q == 16'd1);
    emit_last  = bad || last_lvl;
    // error word: all fields zero except last and error
    err_word            = '0;
    err_word.last_level = 1'b1;
    err_word.error_flag = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!empty_i) state_d = ST_ASIZE;
      ST_ASIZE: state_d = ST_PITCH;
      ST_PITCH: state_d = ST_SLICE;
      ST_SLICE: state_d = ST_PLANE;
      ST_PLANE: state_d = ST_ADD;
      ST_ADD:   state_d = ST_EMIT;
      ST_EMIT:  if (out_load) state_d = emit_last ? ST_IDLE : ST_ASIZE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = (state_q == ST_IDLE) && !empty_i;
    out_load = (state_q == ST_EMIT) && (!out_valid_q || res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          desc_q   <= desc_i;
          w_q      <= desc_i.w;
          h_q      <= desc_i.h;
          d_q      <= desc_i.d;
          pmin_q   <= desc_i.pmin;
          smin_q   <= desc_i.smin;
          lvl_q    <= '0;
          offset_q <= '0;
        end
      end
      ST_ASIZE: begin
        ah_q   <= round_blk(h_q, desc_q.bh);
        prod_q <= aw * desc_q.step;
        chk_q  <= aw * desc_q.bits;
      end
      ST_PITCH: pitch_q <= 32'(pitch_max + amask) & ~amask;
      ST_SLICE: slice_q <= slice_prod[31:0];
      ST_PLANE: begin
        slice_q <= slice_max;
        plane_q <= plane_prod[31:0];
      end
      ST_ADD:   add_q <= add_prod;
      ST_EMIT: begin
        if (out_load) begin
          if (bad) begin
            out_q <= err_word;
          end else begin
            out_q.level_index  <= lvl_q;
            out_q.lvl_width    <= w_q;
            out_q.lvl_height   <= h_q;
            out_q.lvl_depth    <= d_q;
            out_q.step_out     <= desc_q.step;
            out_q.row_pitch    <= pitch_q;
            out_q.slice_bytes  <= slice_q;
            out_q.plane_bytes  <= plane_q;
            out_q.first_offset <= offset_q;
            out_q.total_bytes  <= total;
            out_q.last_level   <= last_lvl;
            out_q.error_flag   <= 1'b0;
          end
          offset_q <= total;
          if (w_q > 16'd1) w_q <= w_q >> 1;
          if (h_q > 16'd1) h_q <= h_q >> 1;
          if (d_q > 16'd1) d_q <= d_q >> 1;
          pmin_q <= '0;
          smin_q <= '0;
          lvl_q  <= lvl_q + LEVEL_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_err_only_level0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.error_flag |-> out_q.level_index == '0 && out_q.last_level)
    else $error("error word not a single level 0 word");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE && state_q != ST_ASIZE |-> lvl_q < LEVEL_W'(MAX_LEVELS))
    else $error("level counter ran past the chain limit");

  a_last_ends_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && emit_last |=> state_q == ST_IDLE)
    else $error("sequencer continued after the last level");

  a_pop_starts_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_ASIZE && lvl_q == '0 && offset_q == '0)
    else $error("new request did not restart level and offset");

endmodule

// ----- rtl/mip_chain_layout.sv -----
// one request in, one word per mip level out, starting at level 0
// the sequencer pops a request from the queue in its idle state, then takes each level through
// ASIZE, PITCH, SLICE, PLANE, ADD and EMIT, waiting in EMIT while the output holds an untaken word;
// an error request gives one word; a 2-entry queue takes requests meanwhile
// reset clears the queue, the sequencer and the output valid; no clearing pass
module mip_chain_layout #(
  parameter int DIM_BITS   = mcl_pkg::DEF_DIM_BITS,
  parameter int MAX_LEVELS = mcl_pkg::DEF_MAX_LEVELS,
  parameter int MAX_LAYERS = mcl_pkg::DEF_MAX_LAYERS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // base_width, base_height, base_depth, bits_per_block, block_width, block_height,
  // step_bits, pitch_min, slice_min, align_request, layer_count, level_limit
  input  logic [mcl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // level_index, lvl_width, lvl_height, lvl_depth, step_out, row_pitch, slice_bytes,
  // plane_bytes, first_offset, total_bytes
  output logic [mcl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  // error_flag
  output logic [0:0]                      m_axis_tuser
);
  import mcl_pkg::*;

  mcl_desc_t   desc_in, desc_out;
  mcl_result_t res;
  logic        full, empty, pop;

  mcl_front #(
    .DIM_BITS  (DIM_BITS),
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_LAYERS(MAX_LAYERS)
  ) u_front (
    .base_width_i    (s_axis_tdata[15:0]),
    .base_height_i   (s_axis_tdata[31:16]),
    .base_depth_i    (s_axis_tdata[47:32]),
    .bits_per_block_i(s_axis_tdata[55:48]),
    .block_width_i   (s_axis_tdata[60:56]),
    .block_height_i  (s_axis_tdata[65:61]),
    .step_bits_i     (s_axis_tdata[75:66]),
    .pitch_min_i     (s_axis_tdata[107:76]),
    .slice_min_i     (s_axis_tdata[139:108]),
    .align_request_i (s_axis_tdata[156:140]),
    .layer_count_i   (s_axis_tdata[165:157]),
    .level_limit_i   (s_axis_tdata[170:166]),
    .desc_o          (desc_in)
  );

  assign s_axis_tready = !full;

  mcl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid),
    .data_i (desc_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (desc_out),
    .empty_o(empty)
  );

  mcl_back #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .desc_i     (desc_out),
    .pop_o      (pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {7'd0, res.total_bytes, res.first_offset, res.plane_bytes,
                         res.slice_bytes, res.row_pitch, res.step_out, res.lvl_depth,
                         res.lvl_height, res.lvl_width, res.level_index};
  assign m_axis_tlast = res.last_level;
  assign m_axis_tuser = res.error_flag;

endmodule

// ----- dv/mip_chain_layout_tb.sv -----
`timescale 1ns / 1ps

module mip_chain_layout_tb;

  import mcl_pkg::*;

  localparam int REQ_W    = 171;
  localparam int WORD_W   = 249;
  localparam int PHASE_A  = 130;
  localparam int PHASE_B  = 260;
  localparam int PAUSE_AT = 150;
  localparam int N_RANDOM = 360;
  localparam int MAX_SHOWN = 40;

  // packed from the top down, so the last field lands in the lowest bits
  typedef struct packed {
    logic [4:0]  lvl_limit;
    logic [8:0]  layer_cnt;
    logic [16:0] align_req;
    logic [31:0] slice_min;
    logic [31:0] pitch_min;
    logic [9:0]  step_bits;
    logic [4:0]  blk_h;
    logic [4:0]  blk_w;
    logic [7:0]  blk_bits;
    logic [15:0] depth;
    logic [15:0] height;
    logic [15:0] width;
  } image_req_t;

  typedef struct packed {
    logic [44:0] total_bytes;
    logic [44:0] first_offset;
    logic [31:0] plane_bytes;
    logic [31:0] slice_bytes;
    logic [31:0] row_pitch;
    logic [9:0]  step_out;
    logic [15:0] depth;
    logic [15:0] height;
    logic [15:0] width;
    logic [4:0]  level;
  } layout_word_t;

  typedef struct packed {
    logic         err;
    logic         last;
    layout_word_t word;
  } level_exp_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // base_width, base_height, base_depth, bits_per_block, block_width, block_height,
  // step_bits, pitch_min, slice_min, align_request, layer_count, level_limit
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // level_index, lvl_width, lvl_height, lvl_depth, step_out, row_pitch, slice_bytes,
  // plane_bytes, first_offset, total_bytes
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  // error_flag
  logic [0:0] m_axis_tuser;

  image_req_t req_q[$];
  level_exp_t level_exp_q[$];
  int sent_cnt = 0;
  int n_req = 0;
  int err_cnt = 0;
  logic req_taken = 1'b0;

  mip_chain_layout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // 0 means 4, anything else rounds up to a power of two
  function automatic bit [31:0] eff_align(bit [16:0] a);
    bit [31:0] p;
    if (a == 0) begin
      return 32'd4;
    end
    p = 32'd1;
    while (p < a && p < 32'h8000_0000) p = p << 1;
    return p;
  endfunction

  function automatic void predict_levels(image_req_t r);
    bit [31:0] w, h, d, bits, bw, bh, stp, pmin, smin, algn, layers, limit;
    bit [31:0] aw, ah, pitch, slice, plane;
    bit [63:0] offset;
    level_exp_t e;
    int n;
    bit done;
    w = (r.width == 0) ? 32'd1 : 32'(r.width);
    h = (r.height == 0) ? 32'd1 : 32'(r.height);
    d = (r.depth == 0) ? 32'd1 : 32'(r.depth);
    bits = r.blk_bits;
    bw = r.blk_w;
    bh = r.blk_h;
    stp = (r.step_bits < r.blk_bits) ? bits : 32'(r.step_bits);
    pmin = r.pitch_min;
    smin = r.slice_min;
    algn = eff_align(r.align_req);
    layers = (r.layer_cnt == 0) ? 32'd1 : 32'(r.layer_cnt);
    if (layers > DEF_MAX_LAYERS) layers = DEF_MAX_LAYERS;
    limit = r.lvl_limit;
    if (limit == 0 || limit > DEF_MAX_LEVELS) limit = DEF_MAX_LEVELS;
    offset = '0;
    n = 0;
    done = 1'b0;
    while (!done) begin
      aw = (w + bw - 32'd1) & ~(bw - 32'd1);
      ah = (h + bh - 32'd1) & ~(bh - 32'd1);
      pitch = aw * stp / 32'd8;
      if (pitch < pmin) pitch = pmin;
      pitch = (pitch + algn - 32'd1) & ~(algn - 32'd1);
      slice = pitch * ah;
      if (slice < smin) slice = smin;
      plane = slice * d;
      // bad format, wrapped base pitch or unaligned base slice: one error word
      if (n == 0 && (bits == 0 || pitch < aw * bits / 32'd8 ||
                     (slice & (algn - 32'd1)) != 0)) begin
        e = '0;
        e.last = 1'b1;
        e.err = 1'b1;
        level_exp_q.push_back(e);
        return;
      end
      e = '0;
      e.word.level = n[4:0];
      e.word.width = w[15:0];
      e.word.height = h[15:0];
      e.word.depth = d[15:0];
      e.word.step_out = stp[9:0];
      e.word.row_pitch = pitch;
      e.word.slice_bytes = slice;
      e.word.plane_bytes = plane;
      e.word.first_offset = offset[44:0];
      offset = offset + 64'(layers) * 64'(plane);
      e.word.total_bytes = offset[44:0];
      n++;
      if (n >= limit || (w == 1 && h == 1 && d == 1)) begin
        e.last = 1'b1;
        done = 1'b1;
      end
      level_exp_q.push_back(e);
      if (w > 1) w = w >> 1;
      if (h > 1) h = h >> 1;
      if (d > 1) d = d >> 1;
      pmin = '0;
      smin = '0;
    end
  endfunction

  task automatic add_req(input bit [15:0] w, input bit [15:0] h, input bit [15:0] d,
                         input bit [7:0] bits, input bit [4:0] bw, input bit [4:0] bh,
                         input bit [9:0] stp, input bit [31:0] pmin, input bit [31:0] smin,
                         input bit [16:0] algn, input bit [8:0] layers,
                         input bit [4:0] limit);
    image_req_t r;
    r.width = w;
    r.height = h;
    r.depth = d;
    r.blk_bits = bits;
    r.blk_w = bw;
    r.blk_h = bh;
    r.step_bits = stp;
    r.pitch_min = pmin;
    r.slice_min = smin;
    r.align_req = algn;
    r.layer_cnt = layers;
    r.lvl_limit = limit;
    req_q.push_back(r);
  endtask

  function automatic bit [15:0] rand_dim();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return 16'($urandom_range(40));
    if (sel < 8) return 16'($urandom_range(65535));
    if (sel == 8) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0;
    return 16'(1 << $urandom_range(15));
  endfunction

  function automatic bit [4:0] rand_blk();
    if ($urandom_range(9) != 0) return 5'(1 << $urandom_range(4));
    return 5'($urandom_range(31));
  endfunction

  task automatic add_random_req();
    bit [7:0]  bits;
    bit [16:0] algn;
    bit [31:0] pmin, smin;
    bit [8:0]  layers;
    int sel;
    bits = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    sel = $urandom_range(9);
    if (sel < 4) algn = 17'(1 << $urandom_range(16));
    else if (sel < 6) algn = '0;
    else algn = 17'($urandom_range(1, 131071));
    sel = $urandom_range(99);
    if (sel < 55) pmin = '0;
    else if (sel < 80) pmin = $urandom_range(1 << 20);
    else if (sel < 92) pmin = $urandom();
    else pmin = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
    sel = $urandom_range(99);
    if (sel < 55) smin = '0;
    else if (sel < 80) smin = $urandom() & ~(eff_align(algn) - 32'd1);
    else smin = $urandom();
    layers = ($urandom_range(9) < 7) ? 9'($urandom_range(8)) : 9'($urandom_range(511));
    add_req(rand_dim(), rand_dim(), rand_dim(), bits, rand_blk(), rand_blk(),
            10'($urandom_range(1023)), pmin, smin, algn, layers, 5'($urandom_range(31)));
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // request driver, one word per handshake; also randomises the output ready
  always @(negedge clk_i) begin : drive_req
    int src_pct;
    int sink_pct;
    if (sent_cnt < PHASE_A) begin
      src_pct = 6;
      sink_pct = 55;
    end else if (sent_cnt < PHASE_B) begin
      src_pct = 55;
      sink_pct = 6;
    end else begin
      src_pct = 0;
      sink_pct = 0;
    end
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        // one hold-off until the layout output has fully drained
        if (req_q.size() != 0 && !(sent_cnt == PAUSE_AT && level_exp_q.size() != 0) &&
            $urandom_range(99) >= src_pct) begin
          s_axis_tdata <= {{(IN_DATA_W-REQ_W){1'b0}}, req_q.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_pct);
    end
  end

  always @(posedge clk_i) begin : watch_bus
    image_req_t r;
    layout_word_t got;
    level_exp_t want;
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      r = s_axis_tdata[REQ_W-1:0];
      predict_levels(r);
      sent_cnt++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[WORD_W-1:0];
      if (level_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("%0t: no word expected, actual %0h last %b err %b", $time,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = level_exp_q.pop_front();
        check_field("level_index", want.word.level, got.level);
        check_field("lvl_width", want.word.width, got.width);
        check_field("lvl_height", want.word.height, got.height);
        check_field("lvl_depth", want.word.depth, got.depth);
        check_field("step_out", want.word.step_out, got.step_out);
        check_field("row_pitch", want.word.row_pitch, got.row_pitch);
        check_field("slice_bytes", want.word.slice_bytes, got.slice_bytes);
        check_field("plane_bytes", want.word.plane_bytes, got.plane_bytes);
        check_field("first_offset", want.word.first_offset, got.first_offset);
        check_field("total_bytes", want.word.total_bytes, got.total_bytes);
        check_field("last_level", want.last, m_axis_tlast);
        check_field("error_flag", want.err, m_axis_tuser);
        check_field("tdata padding", '0, m_axis_tdata[OUT_DATA_W-1:WORD_W]);
      end
    end
  end

  initial begin
    // zero dimensions and all defaults: a single 1x1x1 level
    add_req(0, 0, 0, 8, 1, 1, 0, 0, 0, 0, 0, 0);
    // largest dimensions, full chain, alignment of 65536, max layers
    add_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 16, 16, 1023, 0, 0, 65536, 256, 0);
    // invalid format
    add_req(640, 480, 1, 0, 1, 1, 32, 0, 0, 4, 1, 0);
    // base pitch wraps in the alignment round-up
    add_req(100, 100, 1, 32, 1, 1, 0, 32'hFFFF_FFFF, 0, 4, 1, 0);
    // slice minimums on the base level: an unaligned one below the slice, an aligned one that wins
    add_req(64, 64, 1, 32, 1, 1, 0, 0, 1001, 8, 1, 0);
    add_req(64, 64, 1, 32, 1, 1, 0, 0, 32'h0010_0000, 16, 2, 0);
    // non power of two alignments, pitch minimum wins in the first
    add_req(33, 17, 5, 24, 1, 1, 0, 1000, 0, 5, 3, 0);
    add_req(1000, 300, 1, 64, 4, 4, 0, 0, 0, 65535, 1, 0);
    add_req(1000, 300, 1, 8, 1, 1, 0, 0, 0, 17'h1FFFF, 1, 0);
    // zero, odd and oversized block sizes
    add_req(77, 99, 3, 128, 0, 0, 0, 0, 0, 1, 1, 0);
    add_req(77, 99, 3, 128, 3, 5, 0, 0, 0, 1, 1, 0);
    add_req(77, 99, 3, 128, 31, 31, 200, 0, 0, 2, 1, 0);
    // layer count and level limit saturation
    add_req(256, 256, 256, 16, 1, 1, 0, 0, 0, 4, 511, 0);
    add_req(256, 256, 1, 16, 1, 1, 0, 0, 0, 4, 257, 31);
    add_req(16'hFFFF, 1, 1, 8, 1, 1, 0, 0, 0, 0, 1, 1);
    add_req(40000, 40000, 1, 8, 1, 1, 1023, 0, 0, 4, 256, 17);
    add_req(512, 1, 1, 200, 1, 1, 7, 0, 0, 4, 1, 18);
    // huge minimums, slice wrapping
    add_req(3, 16'hFFFF, 1, 255, 2, 2, 1023, 32'hFFFF_FF00, 0, 256, 1, 0);
    add_req(1, 1, 16'hFFFF, 8, 1, 1, 0, 0, 32'hFFFF_FFFC, 4, 256, 0);
    add_req(16'hFFFF, 16'hFFFF, 1, 255, 1, 1, 1023, 0, 32'hFFFF_FFFF, 1, 256, 0);
    repeat (N_RANDOM) add_random_req();
    n_req = req_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sent_cnt < n_req) @(posedge clk_i);
    while (level_exp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("mip_chain_layout_tb passed");
    end else begin
      $display("mip_chain_layout_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mip_chain_layout_tb failed");
    $finish;
  end

endmodule
